// ===== src/pad_report_decoder_defines.svh =====
// assertion macros shared by the pad report decoder rtl
`ifndef PAD_REPORT_DECODER_DEFINES_SVH
`define PAD_REPORT_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define PRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define PRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PRD_ASSERT_IMPL(lbl, ante, cons, msg)
`define PRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/prd_pkg.sv =====
// shared types and constants for the pad report decoder
package prd_pkg;

  localparam int PAD_COUNT_DEF = 4;
  localparam int REPORT_BYTES  = 37;
  localparam int STORE_DEPTH   = REPORT_BYTES - 1;
  localparam int PAD_GROUP     = 9;

  localparam logic [7:0]  HEADER_CODE   = 8'h21;
  localparam logic [7:0]  THRESH_RESET  = 8'd170;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
  localparam logic [7:0]  STICK_OFFSET  = 8'h80;

  // pad status codes
  localparam logic [1:0] ST_FRESH  = 2'd0;
  localparam logic [1:0] ST_NOCONN = 2'd1;
  localparam logic [1:0] ST_STALE  = 2'd2;

  // configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_TIMEOUT   = 1'b1;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_ERROR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic [12:0]       buttons;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic [7:0]        sl;
    logic [7:0]        sr;
    logic [1:0]        status;
  } pad_rec_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic sweep;
    logic emit;
  } prd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_go;
    logic commit_go;
    logic sweep_done;
    logic emit_done;
  } prd_sts_t;

endpackage

// ===== src/prd_ctrl.sv =====
// controller state machine for the pad report decoder
module prd_ctrl import prd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  prd_sts_t sts,
  output prd_cmd_t cmd
);

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sts.read_go) begin
          state_nxt = S_EMIT;
        end else if (sts.commit_go) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign cmd.take  = (state_r == S_IDLE);
  assign cmd.sweep = (state_r == S_SWEEP);
  assign cmd.emit  = (state_r == S_EMIT);

endmodule

// ===== src/prd_datapath.sv =====
// datapath: report store, commit sweep, pad records, counters and output register
module prd_datapath import prd_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  prd_cmd_t    cmd,
  output prd_sts_t    sts,
  input  logic        in_valid,
  input  logic [1:0]  in_req,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pad_rec_t    out_rec,
  output logic [1:0]  out_pad,
  output logic        out_last
);

  localparam int PW        = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int AW        = $clog2(STORE_DEPTH);
  localparam int SWEEP_LEN = PAD_COUNT * PAD_GROUP;
  localparam logic [AW-1:0] LAST_ADDR = AW'(SWEEP_LEN - 1);
  localparam logic [1:0]    LAST_PAD  = 2'(PAD_COUNT - 1);
  localparam logic [3:0]    LAST_K    = 4'(PAD_GROUP - 1);
  localparam logic [5:0]    LAST_POS  = 6'(REPORT_BYTES - 1);
  localparam logic [5:0]    STORE_TOP = 6'(STORE_DEPTH);

  logic        accept;
  logic        is_byte, is_read, is_tick, is_error;
  logic [7:0]  thr_r;
  logic [15:0] timeout_r;
  logic [5:0]  byte_count_r;
  logic        header_ok_r;
  logic [16:0] idle_r;
  logic        err_r;
  logic        force_go;

  logic [7:0]    store [STORE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data_r;

  logic          sw_issue_r;
  logic [AW-1:0] sw_addr_r;
  logic [3:0]    sw_k_r;
  logic [1:0]    sw_p_r;
  logic          rt_v_r;
  logic [3:0]    rt_k_r;
  logic [1:0]    rt_p_r;
  logic [7:0]    grp_r [PAD_GROUP-1];
  logic          apply;
  logic          nib_ok;
  pad_rec_t      new_rec;

  pad_rec_t   recs [PAD_COUNT];
  logic [1:0] pad_sel_r;
  logic       load;
  logic       out_valid_r;
  pad_rec_t   out_rec_r;
  logic [1:0] out_pad_r;
  logic       out_last_r;

  // item decode
  assign accept   = in_valid && cmd.take;
  assign is_byte  = (in_req == REQ_BYTE);
  assign is_read  = (in_req == REQ_READ);
  assign is_tick  = (in_req == REQ_TICK);
  assign is_error = (in_req == REQ_ERROR);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESH_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r     <= cfg_data[7:0];
        CFG_TIMEOUT:   timeout_r <= cfg_data;
        default:       thr_r     <= thr_r;
      endcase
    end
  end

  // byte counting and header check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      header_ok_r  <= 1'b0;
    end else if (accept && is_byte) begin
      if (in_last) begin
        byte_count_r <= '0;
        header_ok_r  <= 1'b0;
      end else begin
        if (byte_count_r == '0) begin
          header_ok_r <= (in_data == HEADER_CODE);
        end
        if (byte_count_r != '1) begin
          byte_count_r <= byte_count_r + 6'd1;
        end
      end
    end
  end

  assign sts.commit_go = accept && is_byte && in_last && header_ok_r &&
                         (byte_count_r == LAST_POS);
  assign sts.read_go   = accept && is_read;

  // report store, one write and one registered read per cycle
  assign wr_en   = accept && is_byte && (byte_count_r != '0) && (byte_count_r <= STORE_TOP);
  assign wr_addr = AW'(byte_count_r - 6'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= in_data;
    end
    rd_data_r <= store[sw_addr_r];
  end

  // commit sweep: issue addresses and track the byte coming back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_issue_r <= 1'b0;
      sw_addr_r  <= '0;
      sw_k_r     <= '0;
      sw_p_r     <= '0;
      rt_v_r     <= 1'b0;
      rt_k_r     <= '0;
      rt_p_r     <= '0;
    end else if (cmd.take) begin
      sw_issue_r <= sts.commit_go;
      sw_addr_r  <= '0;
      sw_k_r     <= '0;
      sw_p_r     <= '0;
      rt_v_r     <= 1'b0;
    end else if (cmd.sweep) begin
      rt_v_r <= sw_issue_r;
      rt_k_r <= sw_k_r;
      rt_p_r <= sw_p_r;
      if (sw_issue_r) begin
        if (sw_addr_r == LAST_ADDR) begin
          sw_issue_r <= 1'b0;
        end else begin
          sw_addr_r <= sw_addr_r + AW'(1);
        end
        if (sw_k_r == LAST_K) begin
          sw_k_r <= '0;
          sw_p_r <= sw_p_r + 2'd1;
        end else begin
          sw_k_r <= sw_k_r + 4'd1;
        end
      end
    end
  end

  // gather the first bytes of a pad group
  always_ff @(posedge clk) begin
    if (cmd.sweep && rt_v_r && (rt_k_r != LAST_K)) begin
      grp_r[rt_k_r[2:0]] <= rd_data_r;
    end
  end

  // decode one pad once its final byte is back
  assign apply          = cmd.sweep && rt_v_r && (rt_k_r == LAST_K);
  assign sts.sweep_done = apply && (rt_p_r == LAST_PAD);
  assign nib_ok         = (grp_r[0][7:4] == 4'd1) || (grp_r[0][7:4] == 4'd2);

  always_comb begin
    new_rec.buttons = {grp_r[2][0], grp_r[1][3:0], 1'b0, (grp_r[7] >= thr_r),
                       (rd_data_r >= thr_r), grp_r[2][1], grp_r[1][7:4]};
    new_rec.sx      = $signed(grp_r[3] ^ STICK_OFFSET);
    new_rec.sy      = $signed(grp_r[4] ^ STICK_OFFSET);
    new_rec.cx      = $signed(grp_r[5] ^ STICK_OFFSET);
    new_rec.cy      = $signed(grp_r[6] ^ STICK_OFFSET);
    new_rec.sl      = grp_r[7];
    new_rec.sr      = rd_data_r;
    new_rec.status  = ST_FRESH;
  end

  // idle counter and pending error
  assign force_go = sts.read_go && (err_r || (idle_r > {1'b0, timeout_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
      err_r  <= 1'b0;
    end else begin
      if (sts.sweep_done) begin
        idle_r <= '0;
      end else if (accept && is_tick && (idle_r != '1)) begin
        idle_r <= idle_r + 17'd1;
      end
      if (force_go) begin
        err_r <= 1'b0;
      end else if (accept && is_error) begin
        err_r <= 1'b1;
      end
    end
  end

  // pad records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        recs[p] <= '{status: ST_NOCONN, default: '0};
      end
    end else begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        if (force_go) begin
          recs[p].status <= ST_NOCONN;
        end
        if (load && (pad_sel_r == 2'(p)) && (recs[p].status == ST_FRESH)) begin
          recs[p].status <= ST_STALE;
        end
        if (apply && (rt_p_r == 2'(p))) begin
          if (nib_ok) begin
            recs[p] <= new_rec;
          end else begin
            recs[p].status <= ST_NOCONN;
          end
        end
      end
    end
  end

  // record emission into the output register
  assign load          = cmd.emit && (!out_valid_r || out_ready);
  assign sts.emit_done = load && (pad_sel_r == LAST_PAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_sel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (sts.read_go) begin
        pad_sel_r <= '0;
      end else if (load) begin
        pad_sel_r <= pad_sel_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r  <= recs[pad_sel_r[PW-1:0]];
      out_pad_r  <= pad_sel_r;
      out_last_r <= (pad_sel_r == LAST_PAD);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_pad   = out_pad_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/pad_report_decoder.sv =====
// pad report decoder: controller input reports in, pad records out
// Input stream items carry a request kind on in_tuser, a report byte on in_tdata and the
// end-of-report mark on in_tlast. Kinds are report byte, pad read, time tick and error.
// The final byte of a well-formed report starts a commit sweep over the report store, one
// byte per cycle through its single read port, so that item holds in_tready low until the
// sweep is done.
// A pad read moves the controller to its emit state, which loads the records into the
// output register one per cycle while not stalled, the last one flagged by out_tlast.
// Ticks, error events and non-final bytes produce no output item.
// The output register holds a record until out_tready; a stall on the output stalls the
// emission of the remaining records, and new input is taken once the final record of a
// read has been loaded, even while it still waits.
// Configuration writes go through cfg_valid/cfg_ready (always ready) and must be issued
// only while the block is idle.
// Synchronous reset (rst_n low) restores register defaults, marks every pad as not
// connected, clears the idle counter, the pending error and any partial report.
`include "pad_report_decoder_defines.svh"

module pad_report_decoder import prd_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pad_index[1:0], buttons[14:2], main_stick_x[22:15],
                                  // main_stick_y[30:23], c_stick_x[38:31],
                                  // c_stick_y[46:39], slider_left[54:47],
                                  // slider_right[62:55], zero[63]
  output logic [1:0]  out_tuser,  // pad_status[1:0]
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] LAST_PAD = 2'(PAD_COUNT - 1);

  prd_cmd_t   cmd;
  prd_sts_t   sts;
  pad_rec_t   out_rec;
  logic [1:0] out_pad;

  // controller
  prd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath
  prd_datapath #(
    .PAD_COUNT (PAD_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec),
    .out_pad   (out_pad),
    .out_last  (out_tlast)
  );

  // port packing
  assign in_tready = cmd.take;
  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, out_rec.sr, out_rec.sl, out_rec.cy, out_rec.cx,
                      out_rec.sy, out_rec.sx, out_rec.buttons, out_pad};
  assign out_tuser = out_rec.status;

  // checks
  `PRD_ASSERT_NEXT(a_read_blocks_input, in_tvalid && in_tready && (in_tuser == REQ_READ), !in_tready, "input taken while records still to emit")
  `PRD_ASSERT_NEXT(a_commit_blocks_input, sts.commit_go, !in_tready, "input taken during commit sweep")
  `PRD_ASSERT_NEXT(a_sweep_returns_idle, sts.sweep_done, in_tready, "not ready after commit sweep")
  `PRD_ASSERT_IMPL(a_last_record_index, out_tvalid && out_tlast, out_tdata[1:0] == LAST_PAD, "last record flag on wrong pad")

endmodule
